FILE: rtl/lsf_pkg.sv
// Shared types and constants for the learning switch forwarder.
package lsf_pkg;

   localparam int PORT_W        = 3;
   localparam int PORT_SLOTS    = 1 << PORT_W;
   localparam int MAC_W         = 48;
   localparam int MASK_W        = 8;
   localparam int MCAST_BIT     = 40;
   localparam int NUM_PORTS_DEF = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int REQ_DATA_W    = 104;
   localparam int OP_W          = 2;

   localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
   localparam logic [OP_W-1:0] OP_ATTACH = 2'd1;
   localparam logic [OP_W-1:0] OP_DETACH = 2'd2;

   typedef struct packed {
      logic              is_frame;
      logic              is_attach;
      logic              is_detach;
      logic              port_ok;
      logic              excl;
      logic              learn;
      logic              dst_mcast;
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
   } item_type;

endpackage

FILE: rtl/learning_switch_forwarder.sv
// Top level of the learning switch forwarder.
// A request is written into the queue, then looked up and captured in the result register that drives rsp_tvalid.
// Throughput: one word per cycle while rsp_tready is high; the lookup compares all port addresses at once.
// The two-entry queue lets the request side accept up to two more words while rsp_tready is low.
// Reset clears port activity, learned-address valid bits, the queue and the result valid flag.
module learning_switch_forwarder
   import lsf_pkg::*;
#(
   parameter int NUM_PORTS = NUM_PORTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // port[2:0], has_ingress[3], src_mac[51:4], dst_mac[99:52], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // dest_mask[7:0]
   output logic [MASK_W-1:0]     rsp_tdata,
   // flooded[0]
   output logic                  rsp_tuser
);

   logic     q_ready;
   logic     q_push;
   item_type q_in_item;
   logic     q_pop;
   logic     q_valid;
   item_type q_out_item;

   lsf_front #(
      .NUM_PORTS (NUM_PORTS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   lsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_out_item)
   );

   lsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_out_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/lsf_front.sv
// Front end: accepts request words and decodes them into queue entries.
module lsf_front
   import lsf_pkg::*;
#(
   parameter int NUM_PORTS = NUM_PORTS_DEF
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // port[2:0], has_ingress[3], src_mac[51:4], dst_mac[99:52], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  q_ready,
   output logic                  q_push,
   output item_type              q_item
);

   logic              has_ingress;
   logic [PORT_W-1:0] port;
   logic [MAC_W-1:0]  src_mac;
   logic [MAC_W-1:0]  dst_mac;
   logic              port_ok;

   assign port        = req_tdata[PORT_W-1:0];
   assign has_ingress = req_tdata[PORT_W];
   assign src_mac     = req_tdata[PORT_W+1 +: MAC_W];
   assign dst_mac     = req_tdata[PORT_W+1+MAC_W +: MAC_W];
   assign port_ok     = (int'(port) < NUM_PORTS);

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      q_item           = '0;
      q_item.is_frame  = (req_tuser == OP_FRAME);
      q_item.is_attach = (req_tuser == OP_ATTACH);
      q_item.is_detach = (req_tuser == OP_DETACH);
      q_item.port_ok   = port_ok;
      q_item.excl      = has_ingress && port_ok;
      q_item.learn     = has_ingress && port_ok && !src_mac[MCAST_BIT];
      q_item.dst_mcast = dst_mac[MCAST_BIT];
      q_item.port      = port;
      q_item.src_mac   = src_mac;
      q_item.dst_mac   = dst_mac;
   end

endmodule

FILE: rtl/lsf_queue.sv
// Short queue of decoded words between the front and back ends.
module lsf_queue
   import lsf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     push_ready,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/lsf_back.sv
// Back end: port table, learning, destination lookup and the result register.
module lsf_back
   import lsf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [MASK_W-1:0] rsp_tdata,
   output logic              rsp_tuser
);

   logic [PORT_SLOTS-1:0] active_ff, active_in;
   logic [PORT_SLOTS-1:0] mac_valid_ff, mac_valid_in;
   logic [MAC_W-1:0]      learned_ff [PORT_SLOTS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                  rsp_flood_ff, rsp_flood_in;

   logic                  learn_now;
   logic [PORT_SLOTS-1:0] port_sel;
   logic [PORT_SLOTS-1:0] hit;
   logic                  found;
   logic [PORT_W-1:0]     target;
   logic                  flood;
   logic [MASK_W-1:0]     mask;
   logic [MASK_W-1:0]     excl_mask;

   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mask_ff;
   assign rsp_tuser  = rsp_flood_ff;

   assign port_sel  = PORT_SLOTS'(1) << q_item.port;
   assign learn_now = q_item.is_frame && q_item.learn && active_ff[q_item.port];
   assign excl_mask = q_item.excl ? MASK_W'(port_sel) : '0;

   // learning takes effect before the lookup of the same word
   always_comb begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
         if (learn_now && port_sel[i]) begin
            hit[i] = active_ff[i] && (q_item.src_mac == q_item.dst_mac);
         end else begin
            hit[i] = active_ff[i] && mac_valid_ff[i] && (learned_ff[i] == q_item.dst_mac);
         end
      end
   end

   always_comb begin
      found  = 1'b0;
      target = '0;
      for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found  = 1'b1;
            target = PORT_W'(i);
         end
      end
   end

   always_comb begin
      flood = q_item.dst_mcast || !found;
      if (!q_item.is_frame) begin
         mask = '0;
      end else if (flood) begin
         mask = MASK_W'(active_ff) & ~excl_mask;
      end else if (q_item.excl && (target == q_item.port)) begin
         mask = '0;
      end else begin
         mask = MASK_W'(PORT_SLOTS'(1) << target);
      end
   end

   always_comb begin
      active_in    = active_ff;
      mac_valid_in = mac_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_flood_in = rsp_flood_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         rsp_mask_in  = mask;
         rsp_flood_in = q_item.is_frame && flood;
         if ((q_item.is_attach || q_item.is_detach) && q_item.port_ok) begin
            active_in[q_item.port]    = q_item.is_attach;
            mac_valid_in[q_item.port] = 1'b0;
         end
         if (learn_now) begin
            mac_valid_in[q_item.port] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         mac_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         mac_valid_ff <= mac_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mask_ff  <= rsp_mask_in;
      rsp_flood_ff <= rsp_flood_in;
      if (q_pop && learn_now) begin
         learned_ff[q_item.port] <= q_item.src_mac;
      end
   end

   a_ctl_zero: assert property (@(posedge clock) disable iff (reset)
      q_pop && !q_item.is_frame |=> rsp_mask_ff == '0 && !rsp_flood_ff)
      else $error("attach/detach word produced a nonzero result");

   a_unicast_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_flood_ff |-> $onehot0(rsp_mask_ff))
      else $error("unicast result hits more than one port");

   a_mask_active: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_mask_ff & ~MASK_W'($past(active_ff))) == '0)
      else $error("result targets an inactive port");

   a_attach_state: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_item.is_attach && q_item.port_ok |=>
         active_ff[$past(q_item.port)] && !mac_valid_ff[$past(q_item.port)])
      else $error("attach did not activate port and clear its address");

endmodule

FILE: sim/learning_switch_forwarder_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for learning_switch_forwarder: directed and random words against a predictor.
module learning_switch_forwarder_tb;
   import lsf_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int              CYCLE_LIMIT = 400000;
   localparam int              RANDOM_HALF = 900;
   localparam int              POOL_SIZE   = 12;
   localparam logic [MAC_W-1:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [PORT_W-1:0] port;
      logic              ingress;
      logic [MAC_W-1:0]  src;
      logic [MAC_W-1:0]  dst;
   } bridge_word_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              flood;
   } fwd_decision_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [MASK_W-1:0]     rsp_tdata;
   logic                  rsp_tuser;

   // predictor state
   logic [NUM_PORTS_DEF-1:0] port_on = '0;
   logic                     mac_seen [NUM_PORTS_DEF];
   logic [MAC_W-1:0]         mac_table [NUM_PORTS_DEF];

   bridge_word_type  req_backlog [$];
   fwd_decision_type fwd_expected [$];
   bridge_word_type  in_flight;
   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   logic [31:0] cycle_count = '0;

   learning_switch_forwarder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic fwd_decision_type forward_decide(bridge_word_type w);
      fwd_decision_type r;
      logic             hit;
      int               tgt;
      r   = '0;
      hit = 1'b0;
      tgt = 0;
      case (w.op)
         OP_ATTACH, OP_DETACH: begin
            port_on[w.port]  = (w.op == OP_ATTACH);
            mac_seen[w.port] = 1'b0;
         end
         OP_FRAME: begin
            if (w.ingress && port_on[w.port] && !w.src[MCAST_BIT]) begin
               mac_table[w.port] = w.src;
               mac_seen[w.port]  = 1'b1;
            end
            r.flood = w.dst[MCAST_BIT];
            if (!r.flood) begin
               for (int i = 0; i < NUM_PORTS_DEF; i++) begin
                  if (!hit && port_on[i] && mac_seen[i] && mac_table[i] == w.dst) begin
                     hit = 1'b1;
                     tgt = i;
                  end
               end
               r.flood = !hit;
            end
            if (r.flood) begin
               r.mask = port_on;
               if (w.ingress) r.mask[w.port] = 1'b0;
            end else if (!(w.ingress && tgt == w.port)) begin
               r.mask[tgt] = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   task automatic push_item(logic [OP_W-1:0] op, logic [PORT_W-1:0] port, logic ingress,
                            logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst);
      bridge_word_type w;
      w.op      = op;
      w.port    = port;
      w.ingress = ingress;
      w.src     = src;
      w.dst     = dst;
      req_backlog.push_back(w);
      queued_count++;
   endtask

   task automatic push_random(int count);
      int               sel;
      logic [OP_W-1:0]  op;
      logic [MAC_W-1:0] src;
      logic [MAC_W-1:0] dst;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 80)      op = OP_FRAME;
         else if (sel < 89) op = OP_ATTACH;
         else if (sel < 97) op = OP_DETACH;
         else               op = OP_UNUSED;
         if ($urandom_range(0, 49) == 0) mac_pool[$urandom_range(0, POOL_SIZE-1)] = rand_mac();
         src = ($urandom_range(0, 4) != 0) ? mac_pool[$urandom_range(0, POOL_SIZE-1)]
                                           : rand_mac();
         sel = $urandom_range(0, 9);
         if (sel < 7)       dst = mac_pool[$urandom_range(0, POOL_SIZE-1)];
         else if (sel < 9)  dst = rand_mac();
         else               dst = MAC_BCAST;
         push_item(op, PORT_W'($urandom_range(0, 7)), $urandom_range(0, 6) != 0, src, dst);
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || fwd_expected.size() != 0) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            fwd_expected.push_back(forward_decide(in_flight));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               in_flight = req_backlog.pop_front();
               req_tuser <= in_flight.op;
               req_tdata <= {{(REQ_DATA_W-2*MAC_W-PORT_W-1){1'b0}}, in_flight.dst,
                             in_flight.src, in_flight.ingress, in_flight.port};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         case (cycle_count[9:8])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_tready <= (cycle_count % 5 == 0);
            default: rsp_tready <= cycle_count[3];
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      fwd_decision_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fwd_expected.size() == 0) begin
            $error("unexpected word: dest_mask %0h flooded %0b", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = fwd_expected.pop_front();
            if (rsp_tdata !== want.mask) begin
               $error("dest_mask: expected %0h, actual %0h", want.mask, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.flood) begin
               $error("flooded: expected %0b, actual %0b", want.flood, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic [MAC_W-1:0] mac_a;
      logic [MAC_W-1:0] mac_b;
      logic [MAC_W-1:0] mac_d;
      for (int i = 0; i < NUM_PORTS_DEF; i++) begin
         mac_seen[i]  = 1'b0;
         mac_table[i] = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         mac_pool[i] = rand_mac();
         if (i < POOL_SIZE - 2) mac_pool[i][MCAST_BIT] = 1'b0;
      end
      mac_a = 48'h0200_0000_000A;
      mac_b = 48'h0200_0000_000B;
      mac_d = 48'h0200_0000_000D;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // frame with nothing attached: ingress inactive, no learning
      push_item(OP_FRAME,  3'd0, 1'b1, mac_a, mac_b);
      push_item(OP_ATTACH, 3'd0, 1'b0, '0, '0);
      push_item(OP_ATTACH, 3'd3, 1'b0, '0, '0);
      push_item(OP_ATTACH, 3'd7, 1'b0, '0, '0);
      push_item(OP_ATTACH, 3'd3, 1'b0, '0, '0);
      push_item(OP_FRAME,  3'd3, 1'b1, mac_a, MAC_BCAST);
      push_item(OP_FRAME,  3'd0, 1'b1, mac_b, mac_a);
      // known on ingress: drop
      push_item(OP_FRAME,  3'd3, 1'b1, mac_a, mac_a);
      push_item(OP_FRAME,  3'd7, 1'b1, mac_d | (48'd1 << MCAST_BIT), mac_b);
      push_item(OP_FRAME,  3'd0, 1'b0, mac_d, 48'h0200_0000_00CC);
      push_item(OP_FRAME,  3'd3, 1'b0, mac_d, mac_a);
      push_item(OP_DETACH, 3'd3, 1'b0, '0, '0);
      push_item(OP_FRAME,  3'd0, 1'b1, mac_b, mac_a);
      push_item(OP_UNUSED, 3'd5, 1'b1, MAC_BCAST, MAC_BCAST);
      push_item(OP_ATTACH, 3'd3, 1'b0, '0, '0);
      push_item(OP_FRAME,  3'd0, 1'b1, mac_b, mac_a);
      push_item(OP_FRAME,  3'd7, 1'b1, '0, '0);
      push_item(OP_FRAME,  3'd0, 1'b1, 48'hFEFF_FFFF_FFFF, MAC_BCAST);
      // same address on two ports: lowest index wins
      push_item(OP_FRAME,  3'd7, 1'b1, mac_d, MAC_BCAST);
      push_item(OP_FRAME,  3'd3, 1'b1, mac_d, MAC_BCAST);
      push_item(OP_FRAME,  3'd0, 1'b1, mac_b, mac_d);
      push_item(OP_DETACH, 3'd3, 1'b0, '0, '0);
      push_item(OP_FRAME,  3'd0, 1'b1, mac_b, mac_d);

      wait_drained();
      push_random(RANDOM_HALF);
      wait_drained();
      push_random(RANDOM_HALF);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
